FILE: rtl/assert_macros.svh
// Assertion macros for twis_ctrl, the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: rtl/twis_pkg.sv
// ----------------------------------------------------------------------------
// twis_pkg
// Shared types and codes of the trie word insert and search block.
// ----------------------------------------------------------------------------
package twis_pkg;

  localparam int unsigned LetterW = 5;

  typedef logic [LetterW-1:0] letter_t;

  // Operation carried by every letter of a word.
  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_SEARCH = 1'b1
  } func_e;

  // Result status codes.
  typedef enum logic {
    STATUS_OK        = 1'b0,
    STATUS_POOL_FULL = 1'b1
  } status_e;

  // Access strobes toward one memory.
  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

endpackage

FILE: rtl/twis_if.sv
// ----------------------------------------------------------------------------
// twis_if
// Valid/ready channels for letter items and word results.
// ----------------------------------------------------------------------------
interface twis_item_if;
  logic              valid;
  logic              ready;
  twis_pkg::func_e   func;
  twis_pkg::letter_t letter;
  logic              last;

  modport source (output valid, output func, output letter, output last, input ready);
  modport sink (input valid, input func, input letter, input last, output ready);
endinterface

interface twis_result_if;
  logic              valid;
  logic              ready;
  logic              found;
  twis_pkg::status_e status;

  modport source (output valid, output found, output status, input ready);
  modport sink (input valid, input found, input status, output ready);
endinterface

FILE: rtl/twis_ram.sv
// ----------------------------------------------------------------------------
// twis_ram
// Generic single-port RAM with a registered read that holds between reads.
// ----------------------------------------------------------------------------
module twis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/twis_ctrl.sv
// ----------------------------------------------------------------------------
// twis_ctrl
// Sequencer that walks the trie in the link and mark memories, one letter
// at a time, and keeps the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module twis_ctrl #(
  parameter int unsigned NODE_POOL = 1024,
  parameter int unsigned FANOUT    = 26,
  localparam int unsigned NW  = $clog2(NODE_POOL),
  localparam int unsigned LD  = NODE_POOL * FANOUT,
  localparam int unsigned LAW = $clog2(LD)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  twis_item_if.sink            in_i,
  twis_result_if.source        out_o,
  output twis_pkg::mem_ctl_t   link_ctl_o,
  output logic [LAW-1:0]       link_addr_o,
  output logic [NW-1:0]        link_wdata_o,
  input  logic [NW-1:0]        link_rdata_i,
  output twis_pkg::mem_ctl_t   mark_ctl_o,
  output logic [NW-1:0]        mark_addr_o,
  output logic                 mark_wdata_o,
  input  logic                 mark_rdata_i
);

  localparam int unsigned UW = $clog2(NODE_POOL + 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LINK  = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

  state_e         state_q, state_d;
  logic [LAW-1:0] clr_q, clr_d;
  logic [NW-1:0]  cursor_q, cursor_d, cursor_n;
  logic           failed_q, failed_d, failed_n;
  logic           ovf_q, ovf_d, ovf_n;
  logic [UW-1:0]  nodes_q, nodes_d;
  logic           out_valid_q, out_valid_d;

  twis_pkg::func_e func_q;
  logic            last_q;
  logic [LAW-1:0]  slot_q;
  logic            res_search_q;
  logic            res_ok_q;
  logic            res_ovf_q;
  logic            out_found_q;
  logic            out_status_q;

  logic           accept;
  logic           sym_ok;
  logic           step;
  logic [LAW-1:0] slot_in;
  logic           fin_go;
  logic           fin_search;
  logic           load_out;
  logic           pool_full;

  assign accept    = in_i.valid && in_i.ready;
  assign sym_ok    = 32'(in_i.letter) < 32'(FANOUT);
  assign step      = accept && sym_ok && !failed_q && !ovf_q;
  assign slot_in   = LAW'(cursor_q) * LAW'(FANOUT) + LAW'(in_i.letter);
  assign pool_full = nodes_q >= UW'(NODE_POOL);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    nodes_d      = nodes_q;
    cursor_n     = cursor_q;
    failed_n     = failed_q;
    ovf_n        = ovf_q;
    link_ctl_o   = '0;
    link_addr_o  = slot_q;
    link_wdata_o = '0;
    mark_ctl_o   = '0;
    mark_addr_o  = cursor_q;
    mark_wdata_o = 1'b1;
    fin_go       = 1'b0;
    fin_search   = (func_q == twis_pkg::FUNC_SEARCH);
    load_out     = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        link_ctl_o.en  = 1'b1;
        link_ctl_o.we  = 1'b1;
        link_addr_o    = clr_q;
        mark_ctl_o.en  = clr_q < LAW'(NODE_POOL);
        mark_ctl_o.we  = clr_q < LAW'(NODE_POOL);
        mark_addr_o    = clr_q[NW-1:0];
        mark_wdata_o   = 1'b0;
        if (clr_q == LAW'(LD - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + LAW'(1);
        end
      end
      ST_IDLE: begin
        if (step) begin
          link_ctl_o.en = 1'b1;
          link_addr_o   = slot_in;
          state_d       = ST_LINK;
        end else if (accept && in_i.last) begin
          fin_go     = 1'b1;
          fin_search = (in_i.func == twis_pkg::FUNC_SEARCH);
          state_d    = ST_FIN;
        end
      end
      ST_LINK: begin
        if (link_rdata_i != '0) begin
          cursor_n = link_rdata_i;
        end else if (func_q == twis_pkg::FUNC_SEARCH) begin
          failed_n = 1'b1;
        end else if (pool_full) begin
          ovf_n = 1'b1;
        end else begin
          // Claim a fresh node and link it under the current one.
          link_ctl_o.en = 1'b1;
          link_ctl_o.we = 1'b1;
          link_wdata_o  = nodes_q[NW-1:0];
          cursor_n      = nodes_q[NW-1:0];
          nodes_d       = nodes_q + UW'(1);
        end
        if (last_q) begin
          fin_go  = 1'b1;
          state_d = ST_FIN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase

    // The word ends here: a search reads the end mark of its final node, a clean insert sets it.
    if (fin_go) begin
      mark_addr_o = cursor_n;
      if (fin_search) begin
        mark_ctl_o.en = 1'b1;
      end else if (!failed_n && !ovf_n) begin
        mark_ctl_o.en = 1'b1;
        mark_ctl_o.we = 1'b1;
      end
    end
  end

  assign cursor_d = fin_go ? '0 : cursor_n;
  assign failed_d = fin_go ? 1'b0 : failed_n;
  assign ovf_d    = fin_go ? 1'b0 : ovf_n;

  assign out_valid_d = load_out ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cursor_q    <= '0;
      failed_q    <= 1'b0;
      ovf_q       <= 1'b0;
      nodes_q     <= UW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cursor_q    <= cursor_d;
      failed_q    <= failed_d;
      ovf_q       <= ovf_d;
      nodes_q     <= nodes_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      func_q <= in_i.func;
      last_q <= in_i.last;
      slot_q <= slot_in;
    end
    if (fin_go) begin
      res_search_q <= fin_search;
      res_ok_q     <= !failed_n && !ovf_n;
      res_ovf_q    <= ovf_n;
    end
    if (load_out) begin
      out_found_q  <= res_search_q && res_ok_q && mark_rdata_i;
      out_status_q <= !res_search_q && res_ovf_q;
    end
  end

  assign in_i.ready   = (state_q == ST_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.found  = out_found_q;
  assign out_o.status = out_status_q ? twis_pkg::STATUS_POOL_FULL : twis_pkg::STATUS_OK;

  `ASSERT_NEVER(a_no_accept_in_clear, clk_i, rst_ni, (state_q == ST_CLEAR) && in_i.ready)
  `ASSERT_CLK(a_pool_bounds, clk_i, rst_ni, (nodes_q != '0) && (nodes_q <= UW'(NODE_POOL)))
  `ASSERT_CLK(a_alloc_counts, clk_i, rst_ni, ((state_q == ST_LINK) && link_ctl_o.we) |=> (nodes_q == $past(nodes_q) + UW'(1)))
  `ASSERT_CLK(a_result_from_fin, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_FIN))

endmodule

FILE: rtl/trie_word_insert_search_top.sv
// ----------------------------------------------------------------------------
// trie_word_insert_search_top
// Trie of words kept in two on-chip memories, built and searched one letter
// per transfer.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                 Transfer rule
//   in_i     in   func, letter, last      valid && ready at a rising edge
//   out_o    out  found, status           valid && ready at a rising edge
//
// A letter that moves the walk reads its child link in ST_IDLE and uses it
// in ST_LINK, where an insert also writes a new link back into the single
// link memory port. A letter that cannot move the walk needs only ST_IDLE.
// The last letter of a word also starts the end mark memory access, and
// ST_FIN then loads the result into the output register.
// After reset a clearing pass writes every link and end mark to zero, with
// in_i.ready low.
// A result waits in the output register; a stalled output holds the block only
// when the next result is ready to be loaded.
module trie_word_insert_search_top #(
  parameter int unsigned NODE_POOL = 1024,
  parameter int unsigned FANOUT    = 26
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  twis_item_if.sink     in_i,
  twis_result_if.source out_o
);

  // Node index width and link memory geometry.
  localparam int unsigned NW  = $clog2(NODE_POOL);
  localparam int unsigned LD  = NODE_POOL * FANOUT;
  localparam int unsigned LAW = $clog2(LD);

  twis_pkg::mem_ctl_t link_ctl;
  logic [LAW-1:0]     link_addr;
  logic [NW-1:0]      link_wdata;
  logic [NW-1:0]      link_rdata;
  twis_pkg::mem_ctl_t mark_ctl;
  logic [NW-1:0]      mark_addr;
  logic               mark_wdata;
  logic               mark_rdata;

  // The sequencer owns the walk state, the node pool counter and the result.
  twis_ctrl #(
    .NODE_POOL (NODE_POOL),
    .FANOUT    (FANOUT)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .out_o        (out_o),
    .link_ctl_o   (link_ctl),
    .link_addr_o  (link_addr),
    .link_wdata_o (link_wdata),
    .link_rdata_i (link_rdata),
    .mark_ctl_o   (mark_ctl),
    .mark_addr_o  (mark_addr),
    .mark_wdata_o (mark_wdata),
    .mark_rdata_i (mark_rdata)
  );

  // One row of FANOUT child links per node; zero means no child.
  twis_ram #(
    .WIDTH (NW),
    .DEPTH (LD)
  ) u_link_ram (
    .clk_i   (clk_i),
    .en_i    (link_ctl.en),
    .we_i    (link_ctl.we),
    .addr_i  (link_addr),
    .wdata_i (link_wdata),
    .rdata_o (link_rdata)
  );

  // One end-of-word mark per node.
  twis_ram #(
    .WIDTH (1),
    .DEPTH (NODE_POOL)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .en_i    (mark_ctl.en),
    .we_i    (mark_ctl.we),
    .addr_i  (mark_addr),
    .wdata_i (mark_wdata),
    .rdata_o (mark_rdata)
  );

endmodule

FILE: verif/trie_word_insert_search_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trie_word_insert_search_top_tb
// Self-checking bench for the trie word insert and search block. Words go in
// one letter per transfer. A trie model, or a script row's own result, predicts
// each word's result; each result transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module trie_word_insert_search_top_tb;
  import twis_pkg::*;

  localparam int unsigned NODE_POOL = 1024;
  localparam int unsigned FANOUT    = 26;
  localparam int unsigned NodeW     = $clog2(NODE_POOL);

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned N_RANDOM     = 1700;
  localparam int unsigned MAX_WORD     = 24;
  localparam int unsigned WORD_STORE   = 64;
  localparam int unsigned RX_HOLD      = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  // The clearing pass after reset keeps the input stalled while it writes every
  // link slot, so the watchdog limit is a multiple of the link slot count.
  localparam int unsigned STALL_LIMIT  = 4 * NODE_POOL * FANOUT;

  // Letter codes at the edges of the field. Codes from FANOUT upward carry no
  // letter: they move nothing, but a last flag on them still ends the word.
  localparam letter_t LTR_Z    = letter_t'(FANOUT - 1);
  localparam letter_t LTR_NONE = letter_t'(FANOUT);
  localparam letter_t LTR_MAX  = '1;

  typedef logic [NodeW-1:0] node_t;

  typedef struct packed {
    logic    found;
    status_e status;
  } word_result_t;

  // One row of the directed script. Rows with has_exp set carry a result that
  // is plain from the row itself; all other rows rely on the trie model.
  typedef struct packed {
    func_e   op;
    letter_t ltr;
    logic    last;
    logic    has_exp;
    logic    exp_found;
    status_e exp_status;
  } script_row_t;

  typedef struct {
    letter_t     ltr [MAX_WORD];
    int unsigned len;
  } word_t;

  logic clk_i;
  logic rst_ni;

  twis_item_if   in_if ();
  twis_result_if out_if ();

  trie_word_insert_search_top #(
    .NODE_POOL(NODE_POOL),
    .FANOUT   (FANOUT)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Trie model. It keeps its own link table, end marks and node counter, and
  // walks one letter per accepted transfer.
  // --------------------------------------------------------------------------
  node_t       link_tbl [NODE_POOL * FANOUT];
  bit          end_mark [NODE_POOL];
  int unsigned trie_nodes_used;
  node_t       walk_node;
  bit          walk_missed;
  bit          walk_overflow;

  function automatic void trie_clear();
    foreach (link_tbl[i]) link_tbl[i] = '0;
    foreach (end_mark[i]) end_mark[i] = 1'b0;
    trie_nodes_used = 1;
    walk_node       = '0;
    walk_missed     = 1'b0;
    walk_overflow   = 1'b0;
  endfunction

  // Applies one letter. Returns 1 when the letter ends a word, with the
  // word's result in res.
  function automatic bit trie_step(input func_e op, input letter_t ltr,
                                   input logic last, output word_result_t res);
    int unsigned slot;
    node_t       child;
    res.found  = 1'b0;
    res.status = STATUS_OK;
    // Once a search has missed or an insert has run out of nodes, the rest
    // of the word leaves the walk where it is.
    if (ltr < FANOUT && !walk_missed && !walk_overflow) begin
      slot  = int'(walk_node) * FANOUT + int'(ltr);
      child = link_tbl[slot];
      if (child != '0) begin
        walk_node = child;
      end else if (op == FUNC_SEARCH) begin
        walk_missed = 1'b1;
      end else if (trie_nodes_used >= NODE_POOL) begin
        walk_overflow = 1'b1;
      end else begin
        link_tbl[slot]  = node_t'(trie_nodes_used);
        walk_node       = node_t'(trie_nodes_used);
        trie_nodes_used = trie_nodes_used + 1;
      end
    end
    if (!last) return 1'b0;
    // The operation of the closing letter decides what kind of result comes.
    if (op == FUNC_SEARCH) begin
      res.found = !walk_missed && !walk_overflow && end_mark[walk_node];
    end else begin
      if (!walk_missed && !walk_overflow) end_mark[walk_node] = 1'b1;
      if (walk_overflow) res.status = STATUS_POOL_FULL;
    end
    walk_node     = '0;
    walk_missed   = 1'b0;
    walk_overflow = 1'b0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Checker. Results are compared at the rising edge where they transfer; a
  // letter that transfers at the same edge is then fed to the model. A result
  // can never leave in the cycle its closing letter arrives, so the order of
  // the two steps is safe.
  // --------------------------------------------------------------------------
  word_result_t pending_results [$];
  word_result_t head_result;
  word_result_t model_result;
  bit           word_done;
  int unsigned  mismatches;
  int unsigned  idle_run;

  // Result the driver typed in for the letter it is offering, if any.
  logic    drv_has_exp;
  logic    drv_exp_found;
  status_e drv_exp_status;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing pending: found=%0b status=%0d",
                 out_if.found, out_if.status);
          mismatches++;
        end else begin
          head_result = pending_results.pop_front();
          if (out_if.found !== head_result.found) begin
            $error("found: expected %0b, actual %0b", head_result.found, out_if.found);
            mismatches++;
          end
          if (out_if.status !== head_result.status) begin
            $error("status: expected %0d, actual %0d", head_result.status, out_if.status);
            mismatches++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        word_done = trie_step(in_if.func, in_if.letter, in_if.last, model_result);
        if (word_done) begin
          if (drv_has_exp) begin
            model_result.found  = drv_exp_found;
            model_result.status = drv_exp_status;
          end
          pending_results.push_back(model_result);
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
  end

  // The run ends here only if the block stops moving altogether.
  initial begin
    wait (idle_run >= STALL_LIMIT);
    $error("no transfer for %0d cycles", STALL_LIMIT);
    $display("trie_word_insert_search_top regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side. Ready drops in short random bursts while idling is on, once
  // for a long hold that backs the block up into its input, and never in the
  // quiet tail of the run.
  // --------------------------------------------------------------------------
  bit idle_on;
  bit quiet_tail;
  bit rx_hold_req;

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (RX_HOLD) @(negedge clk_i);
        rx_hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (idle_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Letter side. Both tasks are entered at a falling edge and return at one,
  // so valid is written at most once per time step.
  // --------------------------------------------------------------------------
  task automatic offer(input func_e op, input letter_t ltr, input logic last,
                       input logic has_exp, input logic exp_found,
                       input status_e exp_status);
    in_if.func     <= op;
    in_if.letter   <= ltr;
    in_if.last     <= last;
    in_if.valid    <= 1'b1;
    drv_has_exp    = has_exp;
    drv_exp_found  = exp_found;
    drv_exp_status = exp_status;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic hold_off(input int unsigned cycles);
    in_if.valid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Mostly real letters, now and then one of the codes that carry none.
  function automatic letter_t pick_letter();
    if ($urandom_range(0, 15) == 0) return letter_t'($urandom_range(FANOUT, 31));
    return letter_t'($urandom_range(0, FANOUT - 1));
  endfunction

  script_row_t script [$];

  function automatic void add_row(input func_e op, input letter_t ltr, input logic last,
                                  input logic has_exp, input logic exp_found,
                                  input status_e exp_status);
    script.push_back('{op, ltr, last, has_exp, exp_found, exp_status});
  endfunction

  // Directed script, about two dozen letters on a fresh trie. Letters are
  // given as codes: 0 is a, 25 is z.
  initial begin
    // An empty word acts on the root, which starts without an end mark.
    add_row(FUNC_SEARCH, LTR_NONE, 1'b1, 1'b1, 1'b0, STATUS_OK);
    add_row(FUNC_INSERT, LTR_NONE, 1'b1, 1'b1, 1'b0, STATUS_OK);
    // The highest code carries no letter either, so the marked root is found.
    add_row(FUNC_SEARCH, LTR_MAX,  1'b1, 1'b1, 1'b1, STATUS_OK);
    // Insert "az", then look it up and look up its prefix "a".
    add_row(FUNC_INSERT, 5'd0,     1'b0, 1'b0, 1'b0, STATUS_OK);
    add_row(FUNC_INSERT, LTR_Z,    1'b1, 1'b1, 1'b0, STATUS_OK);
    add_row(FUNC_SEARCH, 5'd0,     1'b0, 1'b0, 1'b0, STATUS_OK);
    add_row(FUNC_SEARCH, LTR_Z,    1'b1, 1'b1, 1'b1, STATUS_OK);
    add_row(FUNC_SEARCH, 5'd0,     1'b1, 1'b1, 1'b0, STATUS_OK);
    // A missing first link is a miss, and a miss sticks for the whole word.
    add_row(FUNC_SEARCH, LTR_Z,    1'b1, 1'b1, 1'b0, STATUS_OK);
    add_row(FUNC_SEARCH, LTR_Z,    1'b0, 1'b0, 1'b0, STATUS_OK);
    add_row(FUNC_SEARCH, 5'd0,     1'b1, 1'b1, 1'b0, STATUS_OK);
    // Mixed word: an insert letter, then a search that misses under it.
    add_row(FUNC_INSERT, 5'd1,     1'b0, 1'b0, 1'b0, STATUS_OK);
    add_row(FUNC_SEARCH, 5'd2,     1'b1, 1'b1, 1'b0, STATUS_OK);
    // An insert that closes a word whose search part missed sets no mark.
    add_row(FUNC_SEARCH, 5'd3,     1'b0, 1'b0, 1'b0, STATUS_OK);
    add_row(FUNC_INSERT, 5'd4,     1'b1, 1'b1, 1'b0, STATUS_OK);
    // Codes without a letter inside a word are skipped over.
    add_row(FUNC_INSERT, 5'd5,     1'b0, 1'b0, 1'b0, STATUS_OK);
    add_row(FUNC_INSERT, 5'd28,    1'b0, 1'b0, 1'b0, STATUS_OK);
    add_row(FUNC_INSERT, 5'd6,     1'b1, 1'b0, 1'b0, STATUS_OK);
    add_row(FUNC_SEARCH, 5'd5,     1'b0, 1'b0, 1'b0, STATUS_OK);
    add_row(FUNC_SEARCH, 5'd27,    1'b0, 1'b0, 1'b0, STATUS_OK);
    add_row(FUNC_SEARCH, 5'd6,     1'b1, 1'b0, 1'b0, STATUS_OK);
    // Marking an existing prefix needs no new node.
    add_row(FUNC_INSERT, 5'd0,     1'b1, 1'b0, 1'b0, STATUS_OK);
    add_row(FUNC_SEARCH, 5'd0,     1'b1, 1'b0, 1'b0, STATUS_OK);
    // A word that walks as an insert and ends as a search.
    add_row(FUNC_INSERT, 5'd0,     1'b0, 1'b0, 1'b0, STATUS_OK);
    add_row(FUNC_SEARCH, LTR_Z,    1'b1, 1'b0, 1'b0, STATUS_OK);
  end

  // --------------------------------------------------------------------------
  // Main sequence. After the directed script, words are drawn at random:
  // long fresh inserts dominate until the node pool is used up, so that most
  // of the run walks deep paths and the later part keeps hitting the full
  // pool. Searches reuse remembered words, their prefixes and extensions to
  // get real hits, and mixed or empty words stir in the odd cases.
  // --------------------------------------------------------------------------
  initial begin
    word_t       known [$];
    word_t       pick;
    letter_t     word_ltrs [$];
    func_e       word_ops [$];
    int unsigned dice;
    int unsigned n;
    int unsigned sent;
    int unsigned full_mark;
    int unsigned target;
    bit          pool_full;
    bit          hold_done;
    bit          pause_done;
    bit          filling;

    sent       = 0;
    full_mark  = 0;
    pool_full  = 1'b0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    mismatches = 0;
    idle_run   = 0;
    idle_on    = 1'b1;
    quiet_tail = 1'b0;
    rx_hold_req    = 1'b0;
    drv_has_exp    = 1'b0;
    drv_exp_found  = 1'b0;
    drv_exp_status = STATUS_OK;
    in_if.valid    = 1'b0;
    in_if.func     = FUNC_INSERT;
    in_if.letter   = '0;
    in_if.last     = 1'b0;
    trie_clear();

    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[i]) begin
      if (idle_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 5));
      offer(script[i].op, script[i].ltr, script[i].last, script[i].has_exp,
            script[i].exp_found, script[i].exp_status);
    end

    target = N_RANDOM;
    while (!pool_full || sent < target) begin
      if (!pool_full && trie_nodes_used >= NODE_POOL) begin
        pool_full = 1'b1;
        full_mark = sent;
        if (full_mark + 200 > target) target = full_mark + 200;
      end
      quiet_tail = pool_full && (sent + 150 >= target);
      if ($urandom_range(0, 19) == 0) idle_on = ~idle_on;
      if (quiet_tail) idle_on = 1'b0;

      // Long result-side hold while letters keep coming.
      if (!hold_done && sent >= 400) begin
        rx_hold_req = 1'b1;
        hold_done   = 1'b1;
      end
      // Letter-side pause until every outstanding result is out.
      if (!pause_done && sent >= 900) begin
        in_if.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk_i);
        pause_done = 1'b1;
      end

      word_ltrs.delete();
      word_ops.delete();
      filling = !pool_full;
      dice    = $urandom_range(0, 99);
      if (known.size() > 0) pick = known[$urandom_range(0, known.size() - 1)];

      if (dice < (filling ? 70 : 25)) begin
        // Fresh insert; long while filling the pool.
        n = filling ? $urandom_range(12, MAX_WORD) : $urandom_range(1, 10);
        pick.len = n;
        for (int i = 0; i < n; i++) begin
          pick.ltr[i] = pick_letter();
          word_ltrs.push_back(pick.ltr[i]);
          word_ops.push_back(FUNC_INSERT);
        end
        if (known.size() >= WORD_STORE) known.delete($urandom_range(0, known.size() - 1));
        known.push_back(pick);
      end else if (dice < (filling ? 75 : 35) && known.size() > 0) begin
        for (int i = 0; i < pick.len; i++) begin
          word_ltrs.push_back(pick.ltr[i]);
          word_ops.push_back(FUNC_INSERT);
        end
      end else if (dice < (filling ? 85 : 60) && known.size() > 0) begin
        for (int i = 0; i < pick.len; i++) begin
          word_ltrs.push_back(pick.ltr[i]);
          word_ops.push_back(FUNC_SEARCH);
        end
      end else if (dice < (filling ? 90 : 75) && known.size() > 0) begin
        // A prefix of a known word, at times with one more letter after it.
        n = $urandom_range(1, pick.len);
        for (int i = 0; i < n; i++) begin
          word_ltrs.push_back(pick.ltr[i]);
          word_ops.push_back(FUNC_SEARCH);
        end
        if ($urandom_range(0, 1) == 0) begin
          word_ltrs.push_back(pick_letter());
          word_ops.push_back(FUNC_SEARCH);
        end
      end else if (dice < (filling ? 94 : 85)) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          word_ltrs.push_back(pick_letter());
          word_ops.push_back(FUNC_SEARCH);
        end
      end else if (dice < (filling ? 97 : 93)) begin
        // Mixed operations, over a known word when there is one.
        n = (known.size() > 0) ? pick.len : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          word_ltrs.push_back((known.size() > 0) ? pick.ltr[i] : pick_letter());
          word_ops.push_back(func_e'($urandom_range(0, 1)));
        end
      end
      // Whatever is still empty becomes an empty word on a no-letter code.
      if (word_ltrs.size() == 0) begin
        word_ltrs.push_back(letter_t'($urandom_range(FANOUT, 31)));
        word_ops.push_back(func_e'($urandom_range(0, 1)));
      end

      for (int i = 0; i < word_ltrs.size(); i++) begin
        if (idle_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 5));
        offer(word_ops[i], word_ltrs[i], i == word_ltrs.size() - 1, 1'b0, 1'b0, STATUS_OK);
        sent++;
      end
    end

    // Drain: every pending result must arrive, and nothing may follow it.
    in_if.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("trie_word_insert_search_top regression: pass");
    end else begin
      $display("trie_word_insert_search_top regression: fail");
    end
    $finish;
  end

endmodule
